// ===== hdl/jsu_pkg.sv =====
// shared types, codes and character helpers for the json string unescaper
// no dependencies; used by jsu_decode, jsu_bundle_queue and the top level
package jsu_pkg;

    // parser phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_STR  = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;
    localparam logic [1:0] PH_HEX  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_UNTERM = 2'd2;
    localparam logic [1:0] KIND_BADHEX = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U = 8'h75;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W = $clog2(MAX_RESULTS);

    // all results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        logic [MAX_RESULTS-1:0][7:0]     bytes;
        logic [MAX_RESULTS-1:0][1:0]     kinds;
    } jsu_bundle_t;

    // queue status seen by the top level
    typedef struct packed {
        logic [1:0]       fill;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] head_cnt;
    } jsu_status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } jsu_hex_t;

    function automatic jsu_hex_t hex_value(input logic [7:0] c);
        jsu_hex_t r;
        r.ok = 1'b1;
        r.value = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r.value = c[3:0];
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            r.value = c[3:0] + 4'd9;
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/jsu_decode.sv =====
// phase, hex accumulator and per-byte decode of the unescaper
// depends on jsu_pkg; produces one result bundle per accepted byte
module jsu_decode
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    output jsu_bundle_t bundle
);

    logic [1:0]  phase_reg, phase_next;
    logic [11:0] accum_reg, accum_next;
    logic [1:0]  hex_count_reg, hex_count_next;

    jsu_hex_t    hx;
    logic [15:0] cp;
    logic        closed;
    logic [IDX_W-1:0] n_base;

    always_comb
    begin
        hx = hex_value(in_byte);
        cp = {accum_reg, hx.value};
        closed = 1'b0;
        n_base = '0;
        bundle.bytes = '0;
        bundle.kinds = '0;
        phase_next = phase_reg;
        accum_next = accum_reg;
        hex_count_next = hex_count_reg;

        case (phase_reg)
            PH_STR:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    bundle.kinds[0] = KIND_CLOSED;
                    n_base = IDX_W'(1);
                    phase_next = PH_IDLE;
                    closed = 1'b1;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    bundle.bytes[0] = in_byte;
                    n_base = IDX_W'(1);
                end
            end
            PH_ESC:
            begin
                if (in_byte == CH_U)
                begin
                    accum_next = '0;
                    hex_count_next = '0;
                    phase_next = PH_HEX;
                end
                else
                begin
                    bundle.bytes[0] = escape_map(in_byte);
                    n_base = IDX_W'(1);
                    phase_next = PH_STR;
                end
            end
            PH_HEX:
            begin
                if (!hx.ok)
                begin
                    bundle.kinds[0] = KIND_BADHEX;
                    n_base = IDX_W'(1);
                    phase_next = PH_IDLE;
                    accum_next = '0;
                    hex_count_next = '0;
                    closed = 1'b1;
                end
                else if (hex_count_reg == 2'd3)
                begin
                    // utf-8 encode the finished code point
                    if (cp < 16'h0080)
                    begin
                        bundle.bytes[0] = cp[7:0];
                        n_base = IDX_W'(1);
                    end
                    else if (cp < 16'h0800)
                    begin
                        bundle.bytes[0] = {3'b110, cp[10:6]};
                        bundle.bytes[1] = {2'b10, cp[5:0]};
                        n_base = IDX_W'(2);
                    end
                    else
                    begin
                        bundle.bytes[0] = {4'hE, cp[15:12]};
                        bundle.bytes[1] = {2'b10, cp[11:6]};
                        bundle.bytes[2] = {2'b10, cp[5:0]};
                        n_base = IDX_W'(3);
                    end
                    accum_next = '0;
                    hex_count_next = '0;
                    phase_next = PH_STR;
                end
                else
                begin
                    accum_next = cp[11:0];
                    hex_count_next = hex_count_reg + 2'd1;
                end
            end
            default:
            begin
                // first byte is taken as the opening quote
                phase_next = PH_STR;
            end
        endcase

        bundle.cnt = {1'b0, n_base};
        if (in_end)
        begin
            if (!closed)
            begin
                bundle.kinds[n_base] = KIND_UNTERM;
                bundle.bytes[n_base] = 8'h00;
                bundle.cnt = {1'b0, n_base} + CNT_W'(1);
            end
            phase_next = PH_IDLE;
            accum_next = '0;
            hex_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            accum_reg <= '0;
            hex_count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            hex_count_reg <= hex_count_next;
        end
    end

endmodule

// ===== hdl/jsu_bundle_queue.sv =====
// two-slot queue of result bundles and the unloader that sends their results one per transfer
// depends on jsu_pkg
module jsu_bundle_queue
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  jsu_bundle_t push_bundle,
    output logic        space,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_byte,
    output logic [1:0]  m_kind,
    output logic        m_last,
    output jsu_status_t status
);

    jsu_bundle_t      slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    jsu_bundle_t head;
    logic        xfer;
    logic        pop;

    assign head     = slot_reg[rd_ptr_reg];
    assign m_tvalid = fill_reg != 2'd0;
    assign space    = fill_reg != 2'd2;
    assign m_byte   = head.bytes[idx_reg];
    assign m_kind   = head.kinds[idx_reg];
    assign m_last   = {1'b0, idx_reg} == head.cnt - CNT_W'(1);
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && m_last;

    assign status.fill     = fill_reg;
    assign status.idx      = idx_reg;
    assign status.head_cnt = head.cnt;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
        idx_next = idx_reg;
        if (xfer)
        begin
            idx_next = m_last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
            idx_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_bundle;
        end
    end

endmodule

// ===== hdl/json_string_unescape_core.sv =====
// top level of the streaming json string unescaper
// depends on jsu_pkg, jsu_decode and jsu_bundle_queue
//
// Takes one byte of a quoted json string per transfer and returns the decoded
// bytes, with escapes and backslash-u sequences (as utf-8) resolved, plus
// closed, unterminated and bad-hex markers in tuser. The input side accepts a
// byte every cycle as long as the two-slot bundle queue has room; each byte is
// decoded in the cycle it is taken and its results, up to four, are stored as
// one bundle. The output side sends one result per cycle while m_tready is
// high, so the sustained rate is one input byte per cycle while each byte yields
// at most one result, and an input byte needs one output transfer per result
// (up to four for a three-byte utf-8 sequence followed by the end marker).
// Bytes that cause no result (opening quote, backslash, u, leading hex digits)
// use no queue slot; results pass through the registered bundle queue.
module json_string_unescape_core
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] out_kind
    output logic       m_tlast    // out_last
);

    jsu_bundle_t bundle;
    jsu_status_t status;
    logic        accept;
    logic        push;

    assign accept = s_tvalid && s_tready;
    assign push   = accept && (bundle.cnt != '0);

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_end  (s_tlast),
        .bundle  (bundle)
    );

    jsu_bundle_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (bundle),
        .space       (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_byte      (m_tdata),
        .m_kind      (m_tuser),
        .m_last      (m_tlast),
        .status      (status)
    );

    // queue never holds more than two bundles
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.fill != 2'd3)
        else $error("bundle queue overfilled");

    // a bundle in the queue always holds at least one result and idx stays inside it
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status.head_cnt != '0 && {1'b0, status.idx} < status.head_cnt))
        else $error("result index outside head bundle");

    // decoded bundle never exceeds the result limit
    a_bundle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> bundle.cnt <= CNT_W'(MAX_RESULTS))
        else $error("bundle count too large");

    // a non-final result transfer keeps the queue busy in the next cycle
    a_mid_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("queue drained in the middle of a bundle");

endmodule

// ===== tb/sv/jsu_checker.sv =====
// scoreboard for the json string unescaper: watches both stream channels,
// predicts the results of each accepted byte and compares them in order
// depends on jsu_pkg for the phase and result kind codes
`timescale 1ns / 1ps

module jsu_checker
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast,
    output int         err_count,
    output int         outstanding,
    output int         results_seen
);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } result_t;

    result_t     pending_q[$];
    logic [1:0]  parse_phase;
    logic [15:0] code_acc;
    logic [1:0]  digit_cnt;

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
        begin
            $display("mismatch @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    // works out every result one raw byte causes and queues them in order
    task automatic unescape_byte(input logic [7:0] b, input logic fin);
        result_t     batch[$];
        logic        closed;
        int          nib;
        logic [15:0] cp;
        logic [7:0]  mapped;
        closed = 1'b0;
        nib = -1;
        case (parse_phase)
            PH_STR:
            begin
                if (b == CH_QUOTE)
                begin
                    batch.insert(batch.size(), '{8'h00, KIND_CLOSED, 1'b0});
                    parse_phase = PH_IDLE;
                    closed = 1'b1;
                end
                else if (b == CH_BSLASH)
                begin
                    parse_phase = PH_ESC;
                end
                else
                begin
                    batch.insert(batch.size(), '{b, KIND_DATA, 1'b0});
                end
            end
            PH_ESC:
            begin
                if (b == CH_U)
                begin
                    code_acc = '0;
                    digit_cnt = '0;
                    parse_phase = PH_HEX;
                end
                else
                begin
                    case (b)
                        "b":     mapped = 8'h08;
                        "f":     mapped = 8'h0C;
                        "n":     mapped = 8'h0A;
                        "r":     mapped = 8'h0D;
                        "t":     mapped = 8'h09;
                        default: mapped = b;
                    endcase
                    batch.insert(batch.size(), '{mapped, KIND_DATA, 1'b0});
                    parse_phase = PH_STR;
                end
            end
            PH_HEX:
            begin
                if (b >= "0" && b <= "9")
                begin
                    nib = b - "0";
                end
                else if (b >= "a" && b <= "f")
                begin
                    nib = b - "a" + 10;
                end
                else if (b >= "A" && b <= "F")
                begin
                    nib = b - "A" + 10;
                end
                if (nib < 0)
                begin
                    batch.insert(batch.size(), '{8'h00, KIND_BADHEX, 1'b0});
                    parse_phase = PH_IDLE;
                    code_acc = '0;
                    digit_cnt = '0;
                    closed = 1'b1;
                end
                else
                begin
                    cp = {code_acc[11:0], 4'(nib)};
                    code_acc = cp;
                    if (digit_cnt == 2'd3)
                    begin
                        // utf-8 encoding of the 16-bit code point
                        if (cp < 16'h0080)
                        begin
                            batch.insert(batch.size(), '{cp[7:0], KIND_DATA, 1'b0});
                        end
                        else if (cp < 16'h0800)
                        begin
                            batch.insert(batch.size(), '{{3'b110, cp[10:6]}, KIND_DATA, 1'b0});
                            batch.insert(batch.size(), '{{2'b10, cp[5:0]}, KIND_DATA, 1'b0});
                        end
                        else
                        begin
                            batch.insert(batch.size(), '{{4'b1110, cp[15:12]}, KIND_DATA, 1'b0});
                            batch.insert(batch.size(), '{{2'b10, cp[11:6]}, KIND_DATA, 1'b0});
                            batch.insert(batch.size(), '{{2'b10, cp[5:0]}, KIND_DATA, 1'b0});
                        end
                        code_acc = '0;
                        digit_cnt = '0;
                        parse_phase = PH_STR;
                    end
                    else
                    begin
                        digit_cnt = digit_cnt + 2'd1;
                    end
                end
            end
            default:
            begin
                // idle: the byte is the opening quote whatever its value
                parse_phase = PH_STR;
            end
        endcase
        if (fin)
        begin
            if (!closed)
            begin
                batch.insert(batch.size(), '{8'h00, KIND_UNTERM, 1'b0});
            end
            parse_phase = PH_IDLE;
            code_acc = '0;
            digit_cnt = '0;
        end
        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
        end
        foreach (batch[i])
        begin
            pending_q.insert(pending_q.size(), batch[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            parse_phase = PH_IDLE;
            code_acc = '0;
            digit_cnt = '0;
            pending_q.delete();
            err_count = 0;
            outstanding = 0;
            results_seen = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                unescape_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result data %02h kind %0d last %0d",
                                              m_tdata, m_tuser, m_tlast));
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        report_mismatch($sformatf("result %0d data %02h, wanted %02h",
                                                  results_seen, m_tdata, want.data));
                    end
                    if (m_tuser !== want.kind)
                    begin
                        report_mismatch($sformatf("result %0d kind %0d, wanted %0d",
                                                  results_seen, m_tuser, want.kind));
                    end
                    if (m_tlast !== want.last)
                    begin
                        report_mismatch($sformatf("result %0d last %0d, wanted %0d",
                                                  results_seen, m_tlast, want.last));
                    end
                end
            end
            outstanding = pending_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_json_string_unescape_core.sv =====
// top of the json string unescaper testbench: clock, reset, byte stimulus,
// output back-pressure and the final verdict
// depends on jsu_pkg, jsu_checker and the json_string_unescape_core rtl
`timescale 1ns / 1ps

module tb_json_string_unescape_core;
    import jsu_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int err_count;
    int outstanding;
    int results_seen;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int bytes_sent;
    int strings_sent;

    // {in_end, in_byte} waiting to be sent
    logic [8:0] text_q[$];

    json_string_unescape_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    jsu_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .err_count    (err_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("watchdog expired, %0d results still outstanding", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        text_q.insert(text_q.size(), {fin, b});
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + v;
        end
        return ($urandom_range(1) ? 8'h61 : 8'h41) + (v - 4'd10);
    endfunction

    // called at a falling edge, returns at a falling edge with tvalid still high
    task automatic send_text();
        logic [8:0] item;
        while (text_q.size() > 0)
        begin
            item = text_q.pop_front();
            while ($urandom_range(99) < tx_idle_pct)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
            s_tvalid = 1'b1;
            s_tdata = item[7:0];
            s_tlast = item[8];
            @(posedge clk);
            while (!s_tready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
            bytes_sent++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    // random string: opener (may end there), escapes and plain bytes, an ending
    task automatic queue_string();
        logic [7:0]  c;
        logic [15:0] cp;
        int          ending;
        int          ndig;
        strings_sent++;
        c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CH_QUOTE;
        if ($urandom_range(19) == 0)
        begin
            queue_byte(c, 1'b1);
            return;
        end
        queue_byte(c, 1'b0);
        repeat ($urandom_range(6))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                begin
                    queue_byte(plain_byte(), 1'b0);
                end
                5, 6:
                begin
                    case ($urandom_range(7))
                        0:       c = CH_QUOTE;
                        1:       c = CH_BSLASH;
                        2:       c = "/";
                        3:       c = "b";
                        4:       c = "f";
                        5:       c = "n";
                        6:       c = "r";
                        default: c = "t";
                    endcase
                    queue_byte(CH_BSLASH, 1'b0);
                    queue_byte(c, 1'b0);
                end
                7:
                begin
                    do
                        c = 8'($urandom_range(255));
                    while (c == CH_U);
                    queue_byte(CH_BSLASH, 1'b0);
                    queue_byte(c, 1'b0);
                end
                default:
                begin
                    case ($urandom_range(7))
                        0:       cp = 16'($urandom_range(16'h007F));
                        1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
                        2:       cp = 16'($urandom_range(16'hFFFF, 16'h0800));
                        3:
                        begin
                            case ($urandom_range(5))
                                0:       cp = 16'h0000;
                                1:       cp = 16'h007F;
                                2:       cp = 16'h0080;
                                3:       cp = 16'h07FF;
                                4:       cp = 16'h0800;
                                default: cp = 16'hFFFF;
                            endcase
                        end
                        default: cp = 16'($urandom);
                    endcase
                    queue_byte(CH_BSLASH, 1'b0);
                    queue_byte(CH_U, 1'b0);
                    for (int i = 3; i >= 0; i--)
                    begin
                        queue_byte(hex_char(cp[4*i +: 4]), 1'b0);
                    end
                end
            endcase
        end
        ending = $urandom_range(99);
        if (ending < 55)
        begin
            queue_byte(CH_QUOTE, 1'b0);
        end
        else if (ending < 70)
        begin
            queue_byte(CH_QUOTE, 1'b1);
        end
        else if (ending < 80)
        begin
            queue_byte(plain_byte(), 1'b1);
        end
        else if (ending < 86)
        begin
            queue_byte(CH_BSLASH, 1'b1);
        end
        else if (ending < 93)
        begin
            // text ends inside a hex escape, or right on its last digit
            ndig = $urandom_range(4);
            queue_byte(CH_BSLASH, 1'b0);
            queue_byte(CH_U, ndig == 0);
            for (int i = 0; i < ndig; i++)
            begin
                queue_byte(hex_char(4'($urandom)), i == ndig - 1);
            end
        end
        else
        begin
            ndig = $urandom_range(3);
            queue_byte(CH_BSLASH, 1'b0);
            queue_byte(CH_U, 1'b0);
            repeat (ndig)
            begin
                queue_byte(hex_char(4'($urandom)), 1'b0);
            end
            do
                c = 8'($urandom_range(255));
            while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
            queue_byte(c, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        hold_left = 0;
        bytes_sent = 0;
        strings_sent = 0;
        tx_idle_pct = 19;
        rx_idle_pct = 60;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // end while idle
        queue_byte("A", 1'b1);
        // byte extremes, a letter escape, smallest two-byte code point
        queue_byte(CH_QUOTE, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(CH_BSLASH, 1'b0);
        queue_byte("n", 1'b0);
        queue_byte(CH_BSLASH, 1'b0);
        queue_byte(CH_U, 1'b0);
        queue_byte("0", 1'b0);
        queue_byte("0", 1'b0);
        queue_byte("8", 1'b0);
        queue_byte("0", 1'b0);
        // largest code point with the end flag: three bytes plus unterminated
        queue_byte(CH_BSLASH, 1'b0);
        queue_byte(CH_U, 1'b0);
        queue_byte("F", 1'b0);
        queue_byte("f", 1'b0);
        queue_byte("F", 1'b0);
        queue_byte("f", 1'b1);
        // end right after a backslash
        queue_byte(CH_QUOTE, 1'b0);
        queue_byte(CH_BSLASH, 1'b1);
        // end on the closing quote
        queue_byte(CH_QUOTE, 1'b0);
        queue_byte(CH_QUOTE, 1'b1);
        // bad hex digit, end flag adds nothing
        queue_byte(CH_QUOTE, 1'b0);
        queue_byte(CH_BSLASH, 1'b0);
        queue_byte(CH_U, 1'b0);
        queue_byte("G", 1'b1);
        send_text();

        while (bytes_sent < 110)
        begin
            queue_string();
            send_text();
        end
        wait_drained();

        tx_idle_pct = 60;
        rx_idle_pct = 19;
        while (bytes_sent < 215)
        begin
            queue_string();
            send_text();
        end
        wait_drained();

        // full rate, opening with a long output hold-off so the input backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = 150;
        while (bytes_sent < 320)
        begin
            queue_string();
            send_text();
        end
        wait_drained();
        repeat (16) @(negedge clk);

        $display("sent %0d bytes in %0d random strings plus directed text", bytes_sent,
                 strings_sent);
        $display("checked %0d results, %0d mismatches", results_seen, err_count);
        if (err_count == 0 && outstanding == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
